// ===== hw/rtl/tbrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared widths, constants and controller/datapath command types for the
// token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

    localparam int SecW    = 32;
    localparam int NsW     = 30;
    localparam int TokW    = 32;
    localparam int CfgDatW = 32;
    localparam int CfgIdxW = 2;

    localparam logic [31:0] NsPerSec   = 32'd1_000_000_000;
    localparam logic [31:0] NsPerSecX2 = 32'd2_000_000_000;
    localparam logic [NsW-1:0] NsMax   = 30'd999_999_999;

    // floor(2^61 / 1e9); the quotient estimate taken from the top 32 bits
    // of the dividend falls short by at most two
    localparam logic [31:0] NsRecip    = 32'd2_305_843_009;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RATE     = 2'd0,
        CFG_BURST    = 2'd1,
        CFG_START_S  = 2'd2,
        CFG_START_NS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic capture;   // latch request word
        logic check;     // compute elapsed time
        logic mul_lo;    // nanos * rate + carry
        logic mul_hi;    // secs * rate, quotient estimate
        logic back_mul;  // estimate * 1e9, partial remainder
        logic sum;       // quotient fix-up, whole-second tokens + divided tokens
        logic commit;    // bucket update
        logic load_out;  // result into output register
    } t_cmd;

    typedef struct packed {
        logic deny;
    } t_stat;

endpackage

// ===== hw/rtl/tbrl_req_if.sv =====
// ----------------------------------------------------------------------------
// tbrl_req_if
// Request channel: timestamp word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbrl_req_if import tbrl_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [SecW-1:0] now_seconds;
    logic [NsW-1:0]  now_nanoseconds;

    modport source (output valid, output now_seconds, output now_nanoseconds, input ready);
    modport sink   (input valid, input now_seconds, input now_nanoseconds, output ready);
endinterface

// ===== hw/rtl/tbrl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tbrl_rsp_if
// Response channel: allow/deny word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbrl_rsp_if;
    logic valid;
    logic ready;
    logic allowed;

    modport source (output valid, output allowed, input ready);
    modport sink   (input valid, input allowed, output ready);
endinterface

// ===== hw/rtl/tbrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbrl_ctrl
// Sequencer for one request: check, then, unless denied, two multiplies,
// reciprocal divide, sum and bucket update, then hand-off to the output register.
// ----------------------------------------------------------------------------
module tbrl_ctrl import tbrl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_BACK,
        S_SUM,
        S_COMMIT,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic               r_out_valid;
    t_cmd               cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                n_state   = i_stat.deny ? S_DONE : S_MUL_LO;
            end
            S_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                n_state    = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                n_state    = S_BACK;
            end
            S_BACK: begin
                cmd.back_mul = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // output register free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.load_out)     r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/tbrl_dp.sv =====
// ----------------------------------------------------------------------------
// tbrl_dp
// Datapath: configuration and bucket state, elapsed time, shared-cycle
// multiplies, reciprocal divide by 1e9 and the token update.
// ----------------------------------------------------------------------------
module tbrl_dp import tbrl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgDatW-1:0] i_cfg_data,
    input  logic [SecW-1:0]    i_now_s,
    input  logic [NsW-1:0]     i_now_ns,
    output logic               o_allowed
);

    // configuration
    logic [31:0]     r_rate, r_burst;
    logic [SecW-1:0] r_start_s;
    logic [NsW-1:0]  r_start_ns;
    // bucket state
    logic [TokW-1:0] r_tokens;
    logic [NsW-1:0]  r_carry;
    logic [SecW-1:0] r_last_s;
    logic [NsW-1:0]  r_last_ns;
    // request pipeline
    logic [SecW-1:0] r_now_s, r_secs;
    logic [NsW-1:0]  r_now_ns, r_nanos;
    logic [61:0]     r_low;
    logic [63:0]     r_prod_hi;
    logic [31:0]     r_q_est, r_rem_est;
    logic [NsW-1:0]  r_rem;
    logic [64:0]     r_sum;
    logic            r_result, r_out_allowed;

    // ---- check and elapsed time
    logic            deny;
    logic [SecW-1:0] secs_calc;
    logic [NsW-1:0]  nanos_calc;

    always_comb begin
        deny = (r_rate == '0) || (r_burst == '0) || (32'(r_now_ns) >= NsPerSec) ||
               (r_now_s < r_last_s) || ((r_now_s == r_last_s) && (r_now_ns < r_last_ns));
        if (r_now_ns >= r_last_ns) begin
            secs_calc  = r_now_s - r_last_s;
            nanos_calc = r_now_ns - r_last_ns;
        end else begin
            // borrow one second
            secs_calc  = r_now_s - r_last_s - 1'b1;
            nanos_calc = NsW'(32'(r_now_ns) + NsPerSec - 32'(r_last_ns));
        end
    end

    // ---- low = nanos*rate + carry stays below 2^62, its quotient below 2^32;
    // estimate from the top 32 bits, remainder of the estimate below 3e9
    logic [62:0] recip_prod;
    logic [31:0] back_prod;

    assign recip_prod = 63'(r_low[61:30]) * 63'(NsRecip);
    assign back_prod  = r_q_est * NsPerSec;

    // ---- fix-up of the estimate by 0, 1 or 2
    logic [1:0]     fix;
    logic [31:0]    sub;
    logic [31:0]    q_fix;
    logic [NsW-1:0] rem_fix;

    always_comb begin
        if (r_rem_est >= NsPerSecX2) begin
            fix = 2'd2; sub = NsPerSecX2;
        end else if (r_rem_est >= NsPerSec) begin
            fix = 2'd1; sub = NsPerSec;
        end else begin
            fix = 2'd0; sub = '0;
        end
        q_fix   = r_q_est + 32'(fix);
        rem_fix = NsW'(r_rem_est - sub);
    end

    // ---- bucket update
    logic [TokW-1:0] room, tok_fill;
    logic [NsW-1:0]  carry_next;
    logic            q_big, q_nz;
    logic [31:0]     q_lo;

    always_comb begin
        room  = (r_tokens <= r_burst) ? (r_burst - r_tokens) : '0;
        q_big = |r_sum[64:32];
        q_lo  = r_sum[31:0];
        q_nz  = q_big || (q_lo != '0);
        if (q_nz) begin
            tok_fill   = (q_big || (q_lo >= room)) ? r_burst : (r_tokens + q_lo);
            carry_next = (tok_fill == r_burst) ? '0 : r_rem;
        end else begin
            tok_fill   = r_tokens;
            carry_next = r_rem;
        end
    end

    // ---- config and bucket state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= 32'd1;
            r_burst    <= 32'd1;
            r_start_s  <= '0;
            r_start_ns <= '0;
            r_tokens   <= 32'd1;
            r_carry    <= '0;
            r_last_s   <= '0;
            r_last_ns  <= '0;
        end else if (i_cfg_we) begin
            // any write reloads the bucket from the new settings
            r_tokens <= r_burst;
            r_carry  <= '0;
            r_last_s <= r_start_s;
            r_last_ns <= r_start_ns;
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RATE: r_rate <= i_cfg_data;
                CFG_BURST: begin
                    r_burst  <= i_cfg_data;
                    r_tokens <= i_cfg_data;
                end
                CFG_START_S: begin
                    r_start_s <= i_cfg_data;
                    r_last_s  <= i_cfg_data;
                end
                CFG_START_NS: begin
                    if (32'(i_cfg_data[NsW-1:0]) >= NsPerSec) begin
                        r_start_ns <= NsMax;
                        r_last_ns  <= NsMax;
                    end else begin
                        r_start_ns <= i_cfg_data[NsW-1:0];
                        r_last_ns  <= i_cfg_data[NsW-1:0];
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.commit) begin
            r_carry   <= carry_next;
            r_last_s  <= r_now_s;
            r_last_ns <= r_now_ns;
            if (tok_fill != '0) r_tokens <= tok_fill - 1'b1;
            else                r_tokens <= tok_fill;
        end
    end

    // ---- request pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now_s  <= i_now_s;
            r_now_ns <= i_now_ns;
            r_result <= 1'b0;
        end
        if (i_cmd.check) begin
            r_secs  <= secs_calc;
            r_nanos <= nanos_calc;
        end
        if (i_cmd.mul_lo) r_low <= 62'(r_nanos) * 62'(r_rate) + 62'(r_carry);
        if (i_cmd.mul_hi) begin
            r_prod_hi <= 64'(r_secs) * 64'(r_rate);
            r_q_est   <= recip_prod[62:31];
        end
        if (i_cmd.back_mul) r_rem_est <= r_low[31:0] - back_prod;
        if (i_cmd.sum) begin
            r_sum <= {1'b0, r_prod_hi} + 65'(q_fix);
            r_rem <= rem_fix;
        end
        if (i_cmd.commit)   r_result <= (tok_fill != '0);
        if (i_cmd.load_out) r_out_allowed <= r_result;
    end

    assign o_stat.deny = deny;
    assign o_allowed   = r_out_allowed;

endmodule

// ===== hw/rtl/token_bucket_rate_limiter_unit.sv =====
// A request is captured on accept and checked; a checked request then runs
//   the multiplies, divide, sum and bucket update, a denied one (bad time,
//   time going back, zero rate or burst) goes straight to the output. One request at a
//   time; a result waits while the previous response waits on o_rsp.ready.
// Reset (synchronous, active low): rate 1, burst 1, start time 0, bucket full.
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_unit
// Timestamp-driven token bucket: refills from elapsed time times rate,
// spends one token per allowed request.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter_unit import tbrl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tbrl_req_if.sink           i_req,
    tbrl_rsp_if.source         o_rsp,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgDatW-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    tbrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tbrl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_now_s    (i_req.now_seconds),
        .i_now_ns   (i_req.now_nanoseconds),
        .o_allowed  (o_rsp.allowed)
    );

endmodule
